[rtl/csbp_pkg.sv]
// ----------------------------------------------------------------------------
// csbp_pkg
// Shared types, constants and helpers of the clock-sweep buffer pool.
// ----------------------------------------------------------------------------
package csbp_pkg;

    localparam int SLOTS        = 16;
    localparam int IDX_W        = $clog2(SLOTS);
    localparam int KEY_W        = 32;
    localparam int CNT_W        = 3;
    localparam int SLOT_W       = 4;
    localparam int MAX_PASSES   = 5;
    localparam int SWEEP_VISITS = MAX_PASSES * SLOTS;
    localparam int VIS_W        = $clog2(SWEEP_VISITS);

    localparam logic [CNT_W-1:0] MAX_COUNT  = CNT_W'(5);
    localparam logic [CNT_W-1:0] FILL_COUNT = CNT_W'(1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [VIS_W-1:0] t_visit_cnt;

    typedef enum logic [1:0] {
        MODE_GET     = 2'd0,
        MODE_PUT     = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_TICK    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STAT_HIT   = 3'd0,
        STAT_MISS  = 3'd1,
        STAT_FREE  = 3'd2,
        STAT_EVICT = 3'd3,
        STAT_DROP  = 3'd4,
        STAT_TICK  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_HIT,
        S_SWEEP,
        S_EVRD,
        S_FILL,
        S_TICK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic occ;
        logic pin;
        t_cnt cnt;
    } t_frame;

    typedef struct packed {
        logic match;
        logic can_evict;
        logic can_age;
        t_cnt cnt_dec;
        t_cnt cnt_inc;
    } t_visit;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        t_key                key_out;
        logic                ev_valid;
        t_key                ev_key;
    } t_result;

    // low bits of a frame index, zero extended when the index is narrow
    function automatic logic [SLOT_W-1:0] to_slot(input t_idx idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SLOT_W-1:0];
    endfunction

endpackage

[rtl/csbp_in_if.sv]
// ----------------------------------------------------------------------------
// csbp_in_if
// Request channel: mode and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface csbp_in_if import csbp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

[rtl/csbp_out_if.sv]
// ----------------------------------------------------------------------------
// csbp_out_if
// Result channel: status, slot, returned key and evicted key.
// ----------------------------------------------------------------------------
interface csbp_out_if import csbp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [2:0]              status;
    logic [SLOT_W-1:0]       slot;
    logic signed [KEY_W-1:0] key_out;
    logic                    evicted_valid;
    logic signed [KEY_W-1:0] evicted_key;

    modport source (output valid, output status, output slot, output key_out,
                    output evicted_valid, output evicted_key, input ready);
    modport sink   (input valid, input status, input slot, input key_out,
                    input evicted_valid, input evicted_key, output ready);
endinterface

[rtl/clock_sweep_buffer_pool.sv]
// ----------------------------------------------------------------------------
// clock_sweep_buffer_pool
// Buffer pool of SLOTS frames with clock-sweep replacement.
// ----------------------------------------------------------------------------
// Request channel i_in carries mode (get, put, release, tick) and key; result
// channel o_out carries status, slot, key_out, evicted_valid, evicted_key.
// Both use valid/ready; an item moves when both are high at a clock edge.
// One request is worked at a time; i_in.ready is high only while idle.
// A get, release or put first scans the keys, one key a cycle through the
// key memory read port. A put that misses fills a free frame if there is one,
// else the hand sweeps up to 5 * SLOTS frame visits for a victim and drops
// the put if none is found. A tick ages every frame once, one frame visit per
// cycle.
// The hand walk and key scan share one per-frame compare/count unit.
// Results sit in an output register; the next request is taken as soon as
// the result is parked there, even while o_out.ready is low. A further
// result waits inside until the register frees up.
// Synchronous reset clears all flags, counts and the hand; keys are left
// as they are and are only read from occupied frames.
// ----------------------------------------------------------------------------
module clock_sweep_buffer_pool import csbp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    csbp_in_if.sink          i_in,
    csbp_out_if.source       o_out
);

    logic    s_res_vld;
    logic    s_res_rdy;
    t_result s_res;
    logic    s_mem_we;
    t_idx    s_mem_waddr;
    t_key    s_mem_wdata;
    t_idx    s_mem_raddr;
    t_key    s_mem_rdata;

    logic    r_out_vld;
    t_result r_out;

    csbp_key_store u_keys (
        .i_clk   (i_clk),
        .i_we    (s_mem_we),
        .i_waddr (s_mem_waddr),
        .i_wdata (s_mem_wdata),
        .i_raddr (s_mem_raddr),
        .o_rdata (s_mem_rdata)
    );

    csbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_mode      (i_in.mode),
        .i_key       (i_in.key),
        .o_res_vld   (s_res_vld),
        .i_res_rdy   (s_res_rdy),
        .o_res       (s_res),
        .o_mem_we    (s_mem_we),
        .o_mem_waddr (s_mem_waddr),
        .o_mem_wdata (s_mem_wdata),
        .o_mem_raddr (s_mem_raddr),
        .i_mem_rdata (s_mem_rdata)
    );

    assign s_res_rdy = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_res_rdy) begin
            r_out_vld <= s_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_res_vld && s_res_rdy) begin
            r_out <= s_res;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.status        = r_out.status;
    assign o_out.slot          = r_out.slot;
    assign o_out.key_out       = r_out.key_out;
    assign o_out.evicted_valid = r_out.ev_valid;
    assign o_out.evicted_key   = r_out.ev_key;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request taken while previous one still in work");

    a_evict_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.evicted_valid == (o_out.status == STAT_EVICT)))
        else $error("evicted_valid disagrees with status");

    a_result_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_res_vld && s_res_rdy) |=> (o_out.valid && o_out.status == $past(s_res.status)))
        else $error("result not moved into output register");

    a_tick_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == STAT_TICK) |->
        (o_out.slot == '0 && o_out.key_out == '0 && !o_out.evicted_valid))
        else $error("tick result carries frame data");

endmodule

[rtl/csbp_key_store.sv]
// ----------------------------------------------------------------------------
// csbp_key_store
// Frame key memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module csbp_key_store import csbp_pkg::*; (
    input  logic i_clk,
    input  logic i_we,
    input  t_idx i_waddr,
    input  t_key i_wdata,
    input  t_idx i_raddr,
    output t_key o_rdata
);

    t_key mem [SLOTS];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/csbp_visit_unit.sv]
// ----------------------------------------------------------------------------
// csbp_visit_unit
// Shared per-frame unit: key compare, evict/age decision, count inc/dec.
// ----------------------------------------------------------------------------
module csbp_visit_unit import csbp_pkg::*; (
    input  t_frame i_frame,
    input  t_key   i_key_a,
    input  t_key   i_key_b,
    output t_visit o_visit
);

    logic s_free_to_move;

    assign s_free_to_move    = i_frame.occ && !i_frame.pin;

    assign o_visit.match     = i_frame.occ && (i_key_a == i_key_b);
    assign o_visit.can_evict = s_free_to_move && (i_frame.cnt == '0);
    assign o_visit.can_age   = s_free_to_move && (i_frame.cnt != '0);
    assign o_visit.cnt_dec   = i_frame.cnt - CNT_W'(1);
    assign o_visit.cnt_inc   = (i_frame.cnt < MAX_COUNT) ? i_frame.cnt + CNT_W'(1)
                                                         : i_frame.cnt;

endmodule

[rtl/csbp_ctrl.sv]
// ----------------------------------------------------------------------------
// csbp_ctrl
// Sequencer: key scan, free-frame pick, clock sweep, tick aging, frame state.
// ----------------------------------------------------------------------------
module csbp_ctrl import csbp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic [1:0] i_mode,
    input  t_key    i_key,
    output logic    o_res_vld,
    input  logic    i_res_rdy,
    output t_result o_res,
    output logic    o_mem_we,
    output t_idx    o_mem_waddr,
    output t_key    o_mem_wdata,
    output t_idx    o_mem_raddr,
    input  t_key    i_mem_rdata
);

    localparam t_idx       LAST_IDX   = IDX_W'(SLOTS - 1);
    localparam t_visit_cnt LAST_TICK  = VIS_W'(SLOTS - 1);
    localparam t_visit_cnt LAST_SWEEP = VIS_W'(SWEEP_VISITS - 1);

    t_state     r_state,    n_state;
    t_mode      r_mode,     n_mode;
    t_key       r_key,      n_key;
    t_idx       r_idx,      n_idx;
    t_idx       r_pipe_idx, n_pipe_idx;
    logic       r_pipe_vld, n_pipe_vld;
    logic       r_free_vld, n_free_vld;
    t_idx       r_free_idx, n_free_idx;
    t_idx       r_sel,      n_sel;
    t_idx       r_hand,     n_hand;
    t_visit_cnt r_visit,    n_visit;
    t_result    r_res,      n_res;

    logic       r_occ [SLOTS];
    logic       r_pin [SLOTS];
    t_cnt       r_cnt [SLOTS];

    t_idx       s_fidx;
    t_frame     s_frame;
    t_frame     s_fnew;
    logic       s_fwe;
    t_visit     s_visit;
    t_idx       s_hand_next;

    // one frame is looked at per cycle; pick which
    always_comb begin
        case (r_state)
            S_SCAN:          s_fidx = r_pipe_idx;
            S_SWEEP, S_TICK: s_fidx = r_hand;
            default:         s_fidx = r_sel;
        endcase
    end

    assign s_frame.occ = r_occ[s_fidx];
    assign s_frame.pin = r_pin[s_fidx];
    assign s_frame.cnt = r_cnt[s_fidx];

    assign s_hand_next = (r_hand == LAST_IDX) ? '0 : r_hand + IDX_W'(1);

    csbp_visit_unit u_visit (
        .i_frame (s_frame),
        .i_key_a (r_key),
        .i_key_b (i_mem_rdata),
        .o_visit (s_visit)
    );

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_key      = r_key;
        n_idx      = r_idx;
        n_pipe_idx = r_pipe_idx;
        n_pipe_vld = r_pipe_vld;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_sel      = r_sel;
        n_hand     = r_hand;
        n_visit    = r_visit;
        n_res      = r_res;
        s_fwe      = 1'b0;
        s_fnew     = s_frame;
        o_mem_we   = 1'b0;
        o_mem_raddr = r_idx;
        o_in_ready = 1'b0;
        o_res_vld  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode        = t_mode'(i_mode);
                    n_key         = i_key;
                    n_idx         = '0;
                    n_pipe_vld    = 1'b0;
                    n_free_vld    = 1'b0;
                    n_visit       = '0;
                    n_res         = '0;
                    n_res.status  = STAT_MISS;
                    n_state       = (t_mode'(i_mode) == MODE_TICK) ? S_TICK : S_SCAN;
                end
            end

            // read key r_idx while comparing the key read last cycle
            S_SCAN: begin
                o_mem_raddr = r_idx;
                n_idx       = r_idx + IDX_W'(1);
                n_pipe_idx  = r_idx;
                n_pipe_vld  = 1'b1;
                if (r_pipe_vld) begin
                    if (s_visit.match) begin
                        n_sel   = r_pipe_idx;
                        n_state = S_HIT;
                    end else begin
                        if (!s_frame.occ && !r_free_vld) begin
                            n_free_vld = 1'b1;
                            n_free_idx = r_pipe_idx;
                        end
                        if (r_pipe_idx == LAST_IDX) begin
                            n_state = S_RESOLVE;
                        end
                    end
                end
            end

            S_RESOLVE: begin
                if (r_mode == MODE_PUT) begin
                    if (r_free_vld) begin
                        n_sel        = r_free_idx;
                        n_res.status = STAT_FREE;
                        n_state      = S_FILL;
                    end else begin
                        n_state      = S_SWEEP;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end

            S_HIT: begin
                s_fwe = 1'b1;
                if (r_mode == MODE_RELEASE) begin
                    s_fnew.pin = 1'b0;
                end else begin
                    s_fnew.pin = 1'b1;
                    s_fnew.cnt = s_visit.cnt_inc;
                end
                n_res.status = STAT_HIT;
                n_res.slot   = to_slot(r_sel);
                if (r_mode == MODE_GET) begin
                    n_res.key_out = r_key;
                end
                n_state = S_DONE;
            end

            S_SWEEP: begin
                n_hand  = s_hand_next;
                n_visit = r_visit + VIS_W'(1);
                if (s_visit.can_evict) begin
                    n_sel          = r_hand;
                    n_res.status   = STAT_EVICT;
                    n_res.ev_valid = 1'b1;
                    n_state        = S_EVRD;
                end else begin
                    if (s_visit.can_age) begin
                        s_fwe      = 1'b1;
                        s_fnew.cnt = s_visit.cnt_dec;
                    end
                    if (r_visit == LAST_SWEEP) begin
                        n_res.status = STAT_DROP;
                        n_state      = S_DONE;
                    end
                end
            end

            // fetch the victim key before it is overwritten
            S_EVRD: begin
                o_mem_raddr = r_sel;
                n_state     = S_FILL;
            end

            S_FILL: begin
                o_mem_we   = 1'b1;
                s_fwe      = 1'b1;
                s_fnew.occ = 1'b1;
                s_fnew.pin = 1'b1;
                s_fnew.cnt = FILL_COUNT;
                n_res.slot = to_slot(r_sel);
                if (r_res.status == STAT_EVICT) begin
                    n_res.ev_key = i_mem_rdata;
                end
                n_state = S_DONE;
            end

            S_TICK: begin
                n_hand  = s_hand_next;
                n_visit = r_visit + VIS_W'(1);
                if (s_visit.can_age) begin
                    s_fwe      = 1'b1;
                    s_fnew.cnt = s_visit.cnt_dec;
                end
                if (r_visit == LAST_TICK) begin
                    n_res.status = STAT_TICK;
                    n_state      = S_DONE;
                end
            end

            S_DONE: begin
                o_res_vld = 1'b1;
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_mem_waddr = r_sel;
    assign o_mem_wdata = r_key;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pipe_vld <= 1'b0;
            r_free_vld <= 1'b0;
            r_hand     <= '0;
            r_visit    <= '0;
        end else begin
            r_state    <= n_state;
            r_pipe_vld <= n_pipe_vld;
            r_free_vld <= n_free_vld;
            r_hand     <= n_hand;
            r_visit    <= n_visit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_pipe_idx <= n_pipe_idx;
        r_free_idx <= n_free_idx;
        r_sel      <= n_sel;
        r_res      <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_occ[i] <= 1'b0;
                r_pin[i] <= 1'b0;
                r_cnt[i] <= '0;
            end
        end else if (s_fwe) begin
            r_occ[s_fidx] <= s_fnew.occ;
            r_pin[s_fidx] <= s_fnew.pin;
            r_cnt[s_fidx] <= s_fnew.cnt;
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for clock_sweep_buffer_pool. A short table of get, put,
// release and tick requests runs first, then about 1500 random requests over a
// small, slowly changing key set, so that hits, evictions and drops all occur.
// A shadow pool predicts all results not fixed by the table, compared in order.
// ----------------------------------------------------------------------------
module testbench;
    import csbp_pkg::*;

    localparam int RAND_ITEMS   = 1530;
    localparam int KEY_SET      = 24;
    localparam int DRAIN_CYCLES = SWEEP_VISITS + 2 * SLOTS + 8;

    typedef struct {
        t_mode   mode;
        t_key    key;
        bit      typed;
        t_result want;
    } t_access_row;

    logic i_clk;
    logic i_rst_n;

    csbp_in_if  in_if ();
    csbp_out_if out_if ();

    clock_sweep_buffer_pool u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // shadow copy of the pool
    t_key frame_key [SLOTS];
    t_cnt frame_cnt [SLOTS];
    bit   frame_pin [SLOTS];
    bit   frame_occ [SLOTS];
    int   clock_hand;

    t_result     pending_replies [$];
    t_access_row directed_rows [$];
    t_key        key_set [KEY_SET];
    int          mismatch_cnt = 0;
    int          long_hold_cycles = 0;
    bit          calm = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(4_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int lookup_frame(input t_key k);
        int i;
        for (i = 0; i < SLOTS; i++)
            if (frame_occ[i] && frame_key[i] == k)
                return i;
        return -1;
    endfunction

    // applies one request to the shadow pool and returns the result it gives
    function automatic t_result pool_access(input t_mode m, input t_key k);
        t_result r;
        int      p;
        int      q;
        int      i;
        r        = '0;
        r.status = STAT_MISS;
        p        = lookup_frame(k);
        case (m)
            MODE_GET, MODE_PUT: begin
                if (p >= 0) begin
                    frame_pin[p] = 1'b1;
                    if (frame_cnt[p] < MAX_COUNT)
                        frame_cnt[p]++;
                    r.status = STAT_HIT;
                    r.slot   = SLOT_W'(p);
                    if (m == MODE_GET)
                        r.key_out = frame_key[p];
                end else if (m == MODE_PUT) begin
                    for (i = SLOTS - 1; i >= 0; i--)
                        if (!frame_occ[i])
                            p = i;
                    r.status = STAT_FREE;
                    if (p < 0) begin
                        // hand laps the pool; first unpinned frame at zero goes
                        for (i = 0; i < MAX_PASSES * SLOTS && p < 0; i++) begin
                            q          = clock_hand;
                            clock_hand = (clock_hand + 1) % SLOTS;
                            if (frame_occ[q] && !frame_pin[q]) begin
                                if (frame_cnt[q] == '0) begin
                                    p          = q;
                                    r.status   = STAT_EVICT;
                                    r.ev_valid = 1'b1;
                                    r.ev_key   = frame_key[q];
                                end else begin
                                    frame_cnt[q]--;
                                end
                            end
                        end
                    end
                    if (p >= 0) begin
                        frame_key[p] = k;
                        frame_cnt[p] = FILL_COUNT;
                        frame_pin[p] = 1'b1;
                        frame_occ[p] = 1'b1;
                        r.slot       = SLOT_W'(p);
                    end else begin
                        r.status = STAT_DROP;
                    end
                end
            end
            MODE_RELEASE: begin
                if (p >= 0) begin
                    frame_pin[p] = 1'b0;
                    r.status     = STAT_HIT;
                    r.slot       = SLOT_W'(p);
                end
            end
            default: begin
                // one full lap, hand ends where it began
                for (i = 0; i < SLOTS; i++) begin
                    q          = clock_hand;
                    clock_hand = (clock_hand + 1) % SLOTS;
                    if (frame_occ[q] && !frame_pin[q] && frame_cnt[q] != '0)
                        frame_cnt[q]--;
                end
                r.status = STAT_TICK;
            end
        endcase
        return r;
    endfunction

    task automatic add_row(input t_mode m, input t_key k, input bit typed,
                           input t_status st = STAT_MISS,
                           input logic [SLOT_W-1:0] sl = '0,
                           input t_key ko = '0);
        t_access_row row;
        row.mode         = m;
        row.key          = k;
        row.typed        = typed;
        row.want         = '0;
        row.want.status  = st;
        row.want.slot    = sl;
        row.want.key_out = ko;
        directed_rows.push_back(row);
    endtask

    // called at a falling edge; returns at a falling edge after the item is taken
    task automatic send_access(input t_mode m, input t_key k, input bit typed,
                               input t_result want);
        t_result predicted;
        in_if.valid = 1'b1;
        in_if.mode  = m;
        in_if.key   = k;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predicted = pool_access(m, k);
        pending_replies.push_back(typed ? want : predicted);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_replies.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: result with none expected, status %h slot %h",
                             $time, out_if.status, out_if.slot);
            end else begin
                want = pending_replies.pop_front();
                check_field("status", 32'(want.status), 32'(out_if.status));
                check_field("slot", 32'(want.slot), 32'(out_if.slot));
                check_field("key_out", want.key_out, out_if.key_out);
                check_field("evicted_valid", 32'(want.ev_valid), 32'(out_if.evicted_valid));
                check_field("evicted_key", want.ev_key, out_if.evicted_key);
            end
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_cycles > 0) begin
                stall_left       = long_hold_cycles;
                long_hold_cycles = 0;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    initial begin
        int      i;
        int      r;
        t_mode   m;
        t_key    k;
        t_result none;
        none        = '0;
        in_if.valid = 1'b0;
        in_if.mode  = MODE_GET;
        in_if.key   = '0;
        i_rst_n     = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
            frame_key[i] = '0;
            frame_cnt[i] = '0;
            frame_pin[i] = 1'b0;
            frame_occ[i] = 1'b0;
        end
        clock_hand = 0;

        add_row(MODE_GET, 32'h0000_0000, 1'b1, STAT_MISS);
        add_row(MODE_TICK, 32'hFFFF_FFFF, 1'b1, STAT_TICK);
        add_row(MODE_PUT, 32'h8000_0000, 1'b1, STAT_FREE, SLOT_W'(0));
        add_row(MODE_PUT, 32'h7FFF_FFFF, 1'b1, STAT_FREE, SLOT_W'(1));
        add_row(MODE_GET, 32'h8000_0000, 1'b1, STAT_HIT, SLOT_W'(0), 32'h8000_0000);
        add_row(MODE_PUT, 32'h8000_0000, 1'b0);
        add_row(MODE_RELEASE, 32'h8000_0000, 1'b0);
        add_row(MODE_RELEASE, 32'hFFFF_FFFF, 1'b1, STAT_MISS);
        for (i = 2; i < SLOTS; i++)
            add_row(MODE_PUT, {16'hA5C3, 16'(i)}, 1'b1, STAT_FREE, SLOT_W'(i));
        // pool full: only the released frame can be evicted
        add_row(MODE_PUT, 32'h0000_0000, 1'b0);
        // every frame pinned now
        add_row(MODE_PUT, 32'h0000_0001, 1'b1, STAT_DROP);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < directed_rows.size(); i++)
            send_access(directed_rows[i].mode, directed_rows[i].key,
                        directed_rows[i].typed, directed_rows[i].want);

        for (i = 0; i < KEY_SET; i++)
            key_set[i] = $urandom;

        for (i = 0; i < RAND_ITEMS; i++) begin
            if (i == 400)
                long_hold_cycles = 400;
            if (i == 800) begin
                in_if.valid = 1'b0;
                wait (pending_replies.size() == 0);
                @(negedge i_clk);
            end
            if (i == RAND_ITEMS - 200)
                calm = 1'b1;
            if ($urandom_range(0, 29) == 0)
                key_set[$urandom_range(0, KEY_SET - 1)] = $urandom;
            r = $urandom_range(0, 99);
            if (r < 35)
                m = MODE_PUT;
            else if (r < 60)
                m = MODE_GET;
            else if (r < 88)
                m = MODE_RELEASE;
            else
                m = MODE_TICK;
            if ($urandom_range(0, 15) == 0)
                k = $urandom;
            else
                k = key_set[$urandom_range(0, KEY_SET - 1)];
            send_access(m, k, 1'b0, none);
        end

        in_if.valid = 1'b0;
        wait (pending_replies.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
